// ===== design/rsst_pkg.sv =====
// ----------------------------------------------------------------------------
// rsst_pkg: shared constants and helpers for the range-sum segment tree
// Sizes of the node store, the index fields and the walk stack, plus the
// node index arithmetic used to move through the tree.
// ----------------------------------------------------------------------------
package rsst_pkg;

  // Largest element count the node store is sized for.
  localparam int MAX_ELEMENTS = 1024;
  // Element index width, fixed by the position and range fields.
  localparam int ELEM_W       = 10;
  // Width of a stored sum and of the result.
  localparam int VALUE_BITS   = 32;
  // Every node index of a tree over up to MAX_ELEMENTS elements stays below this.
  localparam int NODE_DEPTH   = 2 * MAX_ELEMENTS;
  localparam int NODE_W       = $clog2(NODE_DEPTH);
  // Width of the used_size register.
  localparam int SIZE_W       = 11;

  // Query walk stack: at most one pending right child per tree level.
  localparam int STACK_DEPTH  = $clog2(MAX_ELEMENTS);
  localparam int SP_W         = $clog2(STACK_DEPTH + 1);
  localparam int STK_IDX_W    = $clog2(STACK_DEPTH);

  // Configuration port layout.
  localparam int PADDR_W      = 3;
  localparam int REG_IDX_W    = PADDR_W - 2;
  localparam int PDATA_W      = 32;
  localparam logic [REG_IDX_W-1:0] REG_USED_SIZE = REG_IDX_W'(0);

  // Operation codes.
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef logic [NODE_W-1:0]     node_idx_t;
  typedef logic [ELEM_W-1:0]     elem_idx_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  // One pending subtree of the query walk.
  typedef struct packed {
    elem_idx_t lo;
    elem_idx_t hi;
    node_idx_t node;
  } span_t;

  function automatic node_idx_t left_child(input node_idx_t n);
    left_child = {n[NODE_W-2:0], 1'b1};
  endfunction

  function automatic node_idx_t right_child(input node_idx_t n);
    right_child = NODE_W'({n[NODE_W-2:0], 1'b1} + NODE_W'(1));
  endfunction

  function automatic node_idx_t parent_of(input node_idx_t n);
    node_idx_t m;
    m = NODE_W'(n - NODE_W'(1));
    parent_of = {1'b0, m[NODE_W-1:1]};
  endfunction

  // A left child has an odd index, its sibling sits one above.
  function automatic node_idx_t sibling_of(input node_idx_t n);
    sibling_of = n[0] ? NODE_W'(n + NODE_W'(1)) : NODE_W'(n - NODE_W'(1));
  endfunction

  function automatic elem_idx_t mid_of(input elem_idx_t lo, input elem_idx_t hi);
    logic [ELEM_W:0] s;
    s = {1'b0, lo} + {1'b0, hi};
    mid_of = s[ELEM_W:1];
  endfunction

endpackage

// ===== design/rsst_ram.sv =====
// ----------------------------------------------------------------------------
// rsst_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rsst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/range_sum_segment_tree_top.sv =====
// ----------------------------------------------------------------------------
// range_sum_segment_tree_top: segment tree with point update and range sum
// Keeps partial sums of up to 1024 signed 32-bit elements in a node RAM and
// walks the tree with a small sequencer around one shared 32-bit adder.
//
//   channel  direction  handshake         payload
//   in_      input      in_valid/in_stall op, position, new_value, range_start, range_end
//   out_     output     out_valid/out_stall range_sum (one beat per query)
//   cfg      input      psel/penable/pready used_size at byte address 0
//
// After reset the node RAM is cleared one entry a cycle, with in_stall held high throughout.
// An update to a leaf L levels deep stalls while it walks L levels down, writes the leaf
// and does L read/add/write steps on the way up.
// A query stalls while it visits nodes (at most four per level) and takes in the last
// read; its result beat is offered as in_stall drops. A dropped update does not stall.
// A waiting result holds the next query in S_QWAIT; no new beat enters meanwhile.
// ----------------------------------------------------------------------------
module range_sum_segment_tree_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [rsst_pkg::ELEM_W-1:0]          in_position,
  input  logic signed [rsst_pkg::VALUE_BITS-1:0] in_new_value,
  input  logic [rsst_pkg::ELEM_W-1:0]          in_range_start,
  input  logic [rsst_pkg::ELEM_W-1:0]          in_range_end,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [rsst_pkg::VALUE_BITS-1:0] out_range_sum,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rsst_pkg::PADDR_W-1:0]         paddr,
  input  logic [rsst_pkg::PDATA_W-1:0]         pwdata,
  output logic [rsst_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_UDESC,
    S_UASC,
    S_QVISIT,
    S_QWAIT
  } state_t;

  state_t                         state_r, state_nxt;
  logic [rsst_pkg::SIZE_W-1:0]    used_size_r, used_size_nxt;
  rsst_pkg::node_idx_t            clr_addr_r, clr_addr_nxt;
  rsst_pkg::elem_idx_t            lo_r, lo_nxt;
  rsst_pkg::elem_idx_t            hi_r, hi_nxt;
  rsst_pkg::node_idx_t            node_r, node_nxt;
  rsst_pkg::elem_idx_t            key_a_r, key_a_nxt;   // position or first
  rsst_pkg::elem_idx_t            key_b_r, key_b_nxt;   // clipped last
  rsst_pkg::value_t               val_r, val_nxt;
  rsst_pkg::value_t               acc_r, acc_nxt;
  logic                           rd_pend_r, rd_pend_nxt;
  rsst_pkg::span_t                stack_r [rsst_pkg::STACK_DEPTH];
  logic [rsst_pkg::SP_W-1:0]      sp_r, sp_nxt;
  logic                           out_valid_r, out_valid_nxt;
  rsst_pkg::value_t               out_sum_r, out_sum_nxt;

  logic                           push;
  rsst_pkg::span_t                push_span;
  rsst_pkg::span_t                top_span;
  rsst_pkg::elem_idx_t            n_m1;
  rsst_pkg::elem_idx_t            clip_last;
  rsst_pkg::elem_idx_t            mid;
  logic                           in_accept;
  logic                           cfg_write;
  logic                           use_rd;
  rsst_pkg::value_t               sum_w;
  rsst_pkg::node_idx_t            par;
  logic                           disjoint;
  logic                           covered;

  logic                           ram_we;
  rsst_pkg::node_idx_t            ram_waddr;
  rsst_pkg::value_t               ram_wdata;
  rsst_pkg::node_idx_t            ram_raddr;
  rsst_pkg::value_t               ram_rdata;

  rsst_ram #(
    .WIDTH (rsst_pkg::VALUE_BITS),
    .DEPTH (rsst_pkg::NODE_DEPTH)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake and configuration port.
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[rsst_pkg::PADDR_W-1:2] == rsst_pkg::REG_USED_SIZE) ?
                     rsst_pkg::PDATA_W'(used_size_r) : '0;
  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

  // Last element index: a size of zero acts as one, oversize is clipped.
  always_comb begin
    if (used_size_r == '0) begin
      n_m1 = '0;
    end else if (used_size_r > rsst_pkg::SIZE_W'(rsst_pkg::MAX_ELEMENTS)) begin
      n_m1 = rsst_pkg::ELEM_W'(rsst_pkg::MAX_ELEMENTS - 1);
    end else begin
      n_m1 = rsst_pkg::ELEM_W'(used_size_r - rsst_pkg::SIZE_W'(1));
    end
  end

  assign clip_last = (in_range_end > n_m1) ? n_m1 : in_range_end;

  // Node arithmetic for the current walk position.
  assign mid      = rsst_pkg::mid_of(lo_r, hi_r);
  assign par      = rsst_pkg::parent_of(node_r);
  assign disjoint = (lo_r > key_b_r) || (hi_r < key_a_r);
  assign covered  = (lo_r >= key_a_r) && (hi_r <= key_b_r);
  assign top_span = stack_r[rsst_pkg::STK_IDX_W'(sp_r - rsst_pkg::SP_W'(1))];

  // The shared adder: ascent sums and query accumulation.
  assign use_rd = (state_r == S_UASC) || rd_pend_r;
  assign sum_w  = acc_r + (use_rd ? ram_rdata : '0);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    used_size_nxt = used_size_r;
    clr_addr_nxt  = clr_addr_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    node_nxt      = node_r;
    key_a_nxt     = key_a_r;
    key_b_nxt     = key_b_r;
    val_nxt       = val_r;
    acc_nxt       = acc_r;
    rd_pend_nxt   = 1'b0;
    sp_nxt        = sp_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_sum_nxt   = out_sum_r;
    push          = 1'b0;
    push_span     = '{lo: rsst_pkg::ELEM_W'(mid + rsst_pkg::ELEM_W'(1)), hi: hi_r,
                      node: rsst_pkg::right_child(node_r)};
    ram_we        = 1'b0;
    ram_waddr     = node_r;
    ram_wdata     = val_r;
    ram_raddr     = node_r;

    if (cfg_write && (paddr[rsst_pkg::PADDR_W-1:2] == rsst_pkg::REG_USED_SIZE)) begin
      used_size_nxt = pwdata[rsst_pkg::SIZE_W-1:0];
    end

    unique case (state_r)
      S_CLR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = rsst_pkg::NODE_W'(clr_addr_r + rsst_pkg::NODE_W'(1));
        if (clr_addr_r == rsst_pkg::NODE_W'(rsst_pkg::NODE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        lo_nxt   = '0;
        hi_nxt   = n_m1;
        node_nxt = '0;
        sp_nxt   = '0;
        acc_nxt  = '0;
        if (in_accept) begin
          if (in_op == rsst_pkg::OP_UPDATE) begin
            key_a_nxt = in_position;
            val_nxt   = in_new_value;
            // An update past the used size is dropped.
            if (in_position <= n_m1) begin
              state_nxt = S_UDESC;
            end
          end else begin
            key_a_nxt = in_range_start;
            key_b_nxt = clip_last;
            state_nxt = (in_range_start > clip_last) ? S_QWAIT : S_QVISIT;
          end
        end
      end

      // Walk down to the leaf; at the leaf write it and fetch its sibling.
      S_UDESC: begin
        if (lo_r == hi_r) begin
          ram_we    = 1'b1;
          ram_waddr = node_r;
          ram_wdata = val_r;
          acc_nxt   = val_r;
          ram_raddr = rsst_pkg::sibling_of(node_r);
          state_nxt = (node_r == '0) ? S_IDLE : S_UASC;
        end else if (key_a_r <= mid) begin
          hi_nxt   = mid;
          node_nxt = rsst_pkg::left_child(node_r);
        end else begin
          lo_nxt   = rsst_pkg::ELEM_W'(mid + rsst_pkg::ELEM_W'(1));
          node_nxt = rsst_pkg::right_child(node_r);
        end
      end

      // One level per cycle: parent = own sum + sibling, fetch next sibling.
      S_UASC: begin
        ram_we    = 1'b1;
        ram_waddr = par;
        ram_wdata = sum_w;
        acc_nxt   = sum_w;
        node_nxt  = par;
        ram_raddr = rsst_pkg::sibling_of(par);
        if (par == '0) begin
          state_nxt = S_IDLE;
        end
      end

      // Depth-first walk; covered nodes are read and added in the next cycle.
      S_QVISIT: begin
        acc_nxt = sum_w;
        if (disjoint || covered) begin
          rd_pend_nxt = covered;
          ram_raddr   = node_r;
          if (sp_r == '0) begin
            state_nxt = S_QWAIT;
          end else begin
            lo_nxt   = top_span.lo;
            hi_nxt   = top_span.hi;
            node_nxt = top_span.node;
            sp_nxt   = rsst_pkg::SP_W'(sp_r - rsst_pkg::SP_W'(1));
          end
        end else begin
          push     = 1'b1;
          sp_nxt   = rsst_pkg::SP_W'(sp_r + rsst_pkg::SP_W'(1));
          hi_nxt   = mid;
          node_nxt = rsst_pkg::left_child(node_r);
        end
      end

      // Take in the last read, then hand the sum to the output register.
      S_QWAIT: begin
        acc_nxt = sum_w;
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = sum_w;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      used_size_r <= rsst_pkg::SIZE_W'(rsst_pkg::MAX_ELEMENTS);
      clr_addr_r  <= '0;
      rd_pend_r   <= 1'b0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_size_r <= used_size_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    node_r    <= node_nxt;
    key_a_r   <= key_a_nxt;
    key_b_r   <= key_b_nxt;
    val_r     <= val_nxt;
    acc_r     <= acc_nxt;
    out_sum_r <= out_sum_nxt;
    if (push) begin
      stack_r[rsst_pkg::STK_IDX_W'(sp_r)] <= push_span;
    end
  end

`ifndef ASSERT_OFF
  // The query walk never writes the node RAM.
  a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_QVISIT) || (state_r == S_QWAIT)) |-> !ram_we)
    else $error("node RAM written during a query");

  // The walk stack never overflows.
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= rsst_pkg::SP_W'(rsst_pkg::STACK_DEPTH))
    else $error("query stack overflow");

  // A dropped update leaves the block ready on the next cycle.
  a_drop_update: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_op == rsst_pkg::OP_UPDATE) && (in_position > n_m1)) |=> !in_stall)
    else $error("out-of-range update not dropped");

  // A result beat is only produced at the end of a query.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_QWAIT))
    else $error("result beat without a finished query");

  // The RAM clearing pass holds off input beats.
  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> in_stall)
    else $error("input accepted during clear");
`endif

endmodule
